[src/cbz_pkg.sv]
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and defaults for the cubic Bezier segment generator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  // width of every coordinate field on the ports
  localparam int FIELD_BITS = 11;

  // default configuration of the core
  localparam int SEGMENTS_DEF   = 50;
  localparam int COORD_BITS_DEF = 11;

  typedef logic [FIELD_BITS-1:0] coord_t;

  // one curve request: four control points
  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } req_t;

  // sideband that travels with each curve point through the back end
  typedef struct packed {
    logic valid;
    logic first;  // point at t = 0, opens a curve
    logic last;   // point at t = 1, closes a curve
  } pt_ctl_t;

endpackage

[src/cbz_if.sv]
// ----------------------------------------------------------------------------
// cbz_if
// Valid/ready channels of the segment generator: curve requests in,
// line segments out.
// ----------------------------------------------------------------------------
interface cbz_req_if;
  logic           valid;
  logic           ready;
  cbz_pkg::coord_t p0_x;
  cbz_pkg::coord_t p0_y;
  cbz_pkg::coord_t p1_x;
  cbz_pkg::coord_t p1_y;
  cbz_pkg::coord_t p2_x;
  cbz_pkg::coord_t p2_y;
  cbz_pkg::coord_t p3_x;
  cbz_pkg::coord_t p3_y;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

interface cbz_seg_if;
  logic            valid;
  logic            ready;
  cbz_pkg::coord_t start_x;
  cbz_pkg::coord_t start_y;
  cbz_pkg::coord_t end_x;
  cbz_pkg::coord_t end_y;
  logic            last_segment;

  modport source (
    output valid, start_x, start_y, end_x, end_y, last_segment,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, last_segment,
    output ready
  );
endinterface

[src/cbz_front.sv]
// ----------------------------------------------------------------------------
// cbz_front
// Request front end: masks the control coordinates to the working width
// and holds up to two requests for the back end.
// ----------------------------------------------------------------------------
module cbz_front #(
  parameter int CW = cbz_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  cbz_req_if.sink             req,
  input  logic                pop,
  output logic                head_valid,
  output cbz_pkg::req_t       head
);

  cbz_pkg::req_t slot [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;
  cbz_pkg::req_t masked;

  // keep only the low working bits of each coordinate
  localparam cbz_pkg::coord_t MASK = cbz_pkg::FIELD_BITS'((64'd1 << CW) - 64'd1);

  always_comb begin
    masked.p0_x = req.p0_x & MASK;
    masked.p0_y = req.p0_y & MASK;
    masked.p1_x = req.p1_x & MASK;
    masked.p1_y = req.p1_y & MASK;
    masked.p2_x = req.p2_x & MASK;
    masked.p2_y = req.p2_y & MASK;
    masked.p3_x = req.p3_x & MASK;
    masked.p3_y = req.p3_y & MASK;
  end

  // two-entry queue handshake
  assign req.ready  = (cnt != 2'd2);
  assign push       = req.valid && req.ready;
  assign head_valid = (cnt != 2'd0);
  assign head       = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wp] <= masked;
  end

endmodule

[src/cbz_seq.sv]
// ----------------------------------------------------------------------------
// cbz_seq
// Back end sequencer: takes a request from the queue and issues its points
// t = 0 .. SEGMENTS / SEGMENTS, one a cycle while en holds, to the pipeline.
// ----------------------------------------------------------------------------
module cbz_seq #(
  parameter int SEGMENTS = cbz_pkg::SEGMENTS_DEF,
  parameter int KW       = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             head_valid,
  input  cbz_pkg::req_t    head,
  output logic             pop,
  output cbz_pkg::req_t    pts,
  output logic [KW-1:0]    k_out,
  output cbz_pkg::pt_ctl_t ctl
);

  logic          busy;
  logic [KW-1:0] k;
  cbz_pkg::req_t held;
  logic          active;
  cbz_pkg::req_t cur;
  logic [KW-1:0] cur_k;
  logic          done;

  // pick the running request or start the next one right away
  always_comb begin
    active = busy || head_valid;
    cur    = busy ? held : head;
    cur_k  = busy ? k : '0;
    done   = (cur_k == KW'(SEGMENTS));
    pop    = en && !busy && head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ctl  <= '0;
    end else if (en) begin
      ctl.valid <= active;
      ctl.first <= (cur_k == '0);
      ctl.last  <= done;
      if (active) busy <= !done;
    end
  end

  // point index and control points of the issued point
  always_ff @(posedge clk) begin
    if (en && active) begin
      k_out <= cur_k;
      pts   <= cur;
      k     <= cur_k + KW'(1);
      held  <= cur;
    end
  end

endmodule

[src/cbz_point.sv]
// ----------------------------------------------------------------------------
// cbz_point
// Curve point pipeline: Bernstein weights from the point index, weighted
// sum of the control coordinates, then a floor divide by SEGMENTS^3 done
// as one multiply by a scaled reciprocal.
// ----------------------------------------------------------------------------
module cbz_point #(
  parameter int SEGMENTS = cbz_pkg::SEGMENTS_DEF,
  parameter int CW       = cbz_pkg::COORD_BITS_DEF,
  parameter int KW       = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cbz_pkg::pt_ctl_t ctl_in,
  input  logic [KW-1:0]    k_in,
  input  cbz_pkg::req_t    pts_in,
  output cbz_pkg::pt_ctl_t ctl_out,
  output logic [CW-1:0]    x_out,
  output logic [CW-1:0]    y_out
);

  localparam int DEN  = SEGMENTS * SEGMENTS * SEGMENTS;
  localparam int WW   = $clog2(DEN + 1);
  localparam int NUMW = CW + WW;
  localparam int PW   = 2 * KW;
  // reciprocal of SEGMENTS^3 scaled by 2^SH and rounded up; its error stays
  // below 2^WW, so the floor is exact for every numerator below 2^NUMW
  localparam int SH   = NUMW + WW;
  localparam int RW   = NUMW + 2;
  localparam int QW   = NUMW + RW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
  // five stages up to the numerator, one for the reciprocal multiply
  localparam int DEPTH = 6;

  // control pipeline, one entry per data stage
  cbz_pkg::pt_ctl_t cp [DEPTH];

  // stage 1: n - k and squares
  logic [KW-1:0] m1, k1;
  logic [PW-1:0] mm1, kk1;
  cbz_pkg::req_t c1;
  // stage 2: the four weights
  logic [WW-1:0] w0, w1, w2, w3;
  cbz_pkg::req_t c2;
  // stage 3: weighted coordinates
  logic [NUMW-1:0] px0, px1, px2, px3, py0, py1, py2, py3;
  // stage 4: pair sums
  logic [NUMW-1:0] sx01, sx23, sy01, sy23;
  // stage 5: numerators
  logic [NUMW-1:0] numx, numy;
  // stage 6: numerators times the reciprocal
  logic [QW-1:0]   qpx, qpy;
  logic [KW-1:0]   m_in;

  assign m_in = KW'(SEGMENTS) - k_in;

  // control travels alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DEPTH; s++) cp[s] <= '0;
    end else if (en) begin
      cp[0] <= ctl_in;
      for (int s = 1; s < DEPTH; s++) cp[s] <= cp[s-1];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= m_in;
      k1  <= k_in;
      mm1 <= PW'(m_in) * PW'(m_in);
      kk1 <= PW'(k_in) * PW'(k_in);
      c1  <= pts_in;

      w0 <= WW'(mm1) * WW'(m1);
      w1 <= WW'(3) * WW'(k1) * WW'(mm1);
      w2 <= WW'(3) * WW'(kk1) * WW'(m1);
      w3 <= WW'(kk1) * WW'(k1);
      c2 <= c1;

      px0 <= NUMW'(c2.p0_x[CW-1:0]) * NUMW'(w0);
      px1 <= NUMW'(c2.p1_x[CW-1:0]) * NUMW'(w1);
      px2 <= NUMW'(c2.p2_x[CW-1:0]) * NUMW'(w2);
      px3 <= NUMW'(c2.p3_x[CW-1:0]) * NUMW'(w3);
      py0 <= NUMW'(c2.p0_y[CW-1:0]) * NUMW'(w0);
      py1 <= NUMW'(c2.p1_y[CW-1:0]) * NUMW'(w1);
      py2 <= NUMW'(c2.p2_y[CW-1:0]) * NUMW'(w2);
      py3 <= NUMW'(c2.p3_y[CW-1:0]) * NUMW'(w3);

      sx01 <= px0 + px1;
      sx23 <= px2 + px3;
      sy01 <= py0 + py1;
      sy23 <= py2 + py3;

      numx <= sx01 + sx23;
      numy <= sy01 + sy23;

      // floor divide by SEGMENTS^3, quotient sits at bit SH
      qpx <= QW'(numx) * QW'(RECIP);
      qpy <= QW'(numy) * QW'(RECIP);
    end
  end

  assign ctl_out = cp[DEPTH - 1];
  assign x_out   = qpx[SH +: CW];
  assign y_out   = qpy[SH +: CW];

endmodule

[src/cbz_seg_out.sv]
// ----------------------------------------------------------------------------
// cbz_seg_out
// Segment builder: pairs each curve point with the one before it and
// holds the finished segment in the output register.
// ----------------------------------------------------------------------------
module cbz_seg_out #(
  parameter int CW = cbz_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cbz_pkg::pt_ctl_t ctl_in,
  input  logic [CW-1:0]    x_in,
  input  logic [CW-1:0]    y_in,
  output logic             en,
  cbz_seg_if.source        seg
);

  logic [CW-1:0] prev_x;
  logic [CW-1:0] prev_y;
  logic          emit;

  // the whole back end advances whenever the output register can take data
  assign en   = !seg.valid || seg.ready;
  assign emit = ctl_in.valid && !ctl_in.first;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (en) begin
      seg.valid <= emit;
    end
  end

  // segment payload and running start point
  always_ff @(posedge clk) begin
    if (en && ctl_in.valid) begin
      prev_x <= x_in;
      prev_y <= y_in;
    end
    if (en && emit) begin
      seg.start_x      <= cbz_pkg::FIELD_BITS'(prev_x);
      seg.start_y      <= cbz_pkg::FIELD_BITS'(prev_y);
      seg.end_x        <= cbz_pkg::FIELD_BITS'(x_in);
      seg.end_y        <= cbz_pkg::FIELD_BITS'(y_in);
      seg.last_segment <= ctl_in.last;
    end
  end

endmodule

[src/cubic_bezier_segment_generator_core.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_segment_generator_core
// Turns a request of four control points into SEGMENTS line segments along
// the cubic Bezier curve, with exact integer point evaluation.
// ----------------------------------------------------------------------------
// The single point pipeline evaluates the SEGMENTS + 1 curve points of a
// request (the start point included), one per cycle while the segment side
// does not stall, so a steady stream gives one segment per cycle with a gap
// between curves, as each start point yields no segment. Each curve point
// passes through the sequencer register, the stages of weights, products and
// sums, the stage that divides by SEGMENTS^3 through a multiply by its
// scaled reciprocal, and the output register. Two requests are queued ahead
// of the pipeline, and a stall on the segment side holds the whole back end.
module cubic_bezier_segment_generator_core #(
  parameter int SEGMENTS   = cbz_pkg::SEGMENTS_DEF,
  parameter int COORD_BITS = cbz_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cbz_req_if.sink    req,
  cbz_seg_if.source  seg
);

  localparam int KW = $clog2(SEGMENTS + 1);
  localparam int CW = (COORD_BITS < cbz_pkg::FIELD_BITS) ? COORD_BITS
                                                          : cbz_pkg::FIELD_BITS;

  logic             head_valid;
  cbz_pkg::req_t    head;
  logic             pop;
  logic             en;
  cbz_pkg::req_t    pts;
  logic [KW-1:0]    k;
  cbz_pkg::pt_ctl_t seq_ctl;
  cbz_pkg::pt_ctl_t pt_ctl;
  logic [CW-1:0]    pt_x;
  logic [CW-1:0]    pt_y;

  // request queue
  cbz_front #(.CW(CW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // point index sequencer
  cbz_seq #(.SEGMENTS(SEGMENTS), .KW(KW)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pts        (pts),
    .k_out      (k),
    .ctl        (seq_ctl)
  );

  // curve point evaluation
  cbz_point #(.SEGMENTS(SEGMENTS), .CW(CW), .KW(KW)) u_point (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (seq_ctl),
    .k_in    (k),
    .pts_in  (pts),
    .ctl_out (pt_ctl),
    .x_out   (pt_x),
    .y_out   (pt_y)
  );

  // segment assembly and output register
  cbz_seg_out #(.CW(CW)) u_seg_out (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (pt_ctl),
    .x_in   (pt_x),
    .y_in   (pt_y),
    .en     (en),
    .seg    (seg)
  );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic Bezier segment generator. Curve requests
// go in through the request channel. Each one is expanded into its line
// segments by an exact integer model of the curve, and every segment that
// comes out is compared with the oldest one still outstanding. Outside the
// streaming test the sender works in random bursts, and the segment side stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGS       = cbz_pkg::SEGMENTS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 40;
  localparam int MAX_PRINTS = 20;

  localparam cbz_pkg::coord_t COORD_MAX = '1;

  // one expected line segment
  typedef struct packed {
    cbz_pkg::coord_t start_x;
    cbz_pkg::coord_t start_y;
    cbz_pkg::coord_t end_x;
    cbz_pkg::coord_t end_y;
    logic            last_segment;
  } segment_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG
  } stall_style_t;

  logic clk;
  logic rst;

  cbz_req_if req_ch ();
  cbz_seg_if seg_ch ();

  cubic_bezier_segment_generator_core #(
    .SEGMENTS  (SEGS),
    .COORD_BITS(cbz_pkg::COORD_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .seg(seg_ch)
  );

  segment_t     pending_segments[$];
  stall_style_t stall_style;
  bit           sender_gaps;
  int           burst_left;
  int           err_count;
  int           curves_sent;
  int           segments_checked;
  int           idle_cycles;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // exact curve coordinate at step k of SEGS on one axis, floored
  function automatic cbz_pkg::coord_t bezier_axis(
    cbz_pkg::coord_t c0, cbz_pkg::coord_t c1, cbz_pkg::coord_t c2, cbz_pkg::coord_t c3,
    int unsigned k);
    longint unsigned n, m, kk, num;
    n   = SEGS;
    kk  = k;
    m   = n - kk;
    num = 64'(c0) * m * m * m + 64'd3 * 64'(c1) * kk * m * m
        + 64'd3 * 64'(c2) * kk * kk * m + 64'(c3) * kk * kk * kk;
    return cbz_pkg::coord_t'(num / (n * n * n));
  endfunction

  // expand one request into the segments it must produce
  task automatic expand_curve(input cbz_pkg::req_t r);
    cbz_pkg::coord_t px, py;
    segment_t        s;
    px = r.p0_x;
    py = r.p0_y;
    for (int k = 1; k <= SEGS; k++) begin
      s.start_x      = px;
      s.start_y      = py;
      s.end_x        = bezier_axis(r.p0_x, r.p1_x, r.p2_x, r.p3_x, k);
      s.end_y        = bezier_axis(r.p0_y, r.p1_y, r.p2_y, r.p3_y, k);
      s.last_segment = (k == SEGS);
      pending_segments.push_back(s);
      px = s.end_x;
      py = s.end_y;
    end
  endtask

  // drive one request, with a random gap between bursts
  task automatic send_curve(input cbz_pkg::req_t r);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.p0_x  <= r.p0_x;
    req_ch.p0_y  <= r.p0_y;
    req_ch.p1_x  <= r.p1_x;
    req_ch.p1_y  <= r.p1_y;
    req_ch.p2_x  <= r.p2_x;
    req_ch.p2_y  <= r.p2_y;
    req_ch.p3_x  <= r.p3_x;
    req_ch.p3_y  <= r.p3_y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expand_curve(r);
    curves_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  function automatic cbz_pkg::req_t make_curve(
    cbz_pkg::coord_t ax, cbz_pkg::coord_t ay, cbz_pkg::coord_t bx, cbz_pkg::coord_t by,
    cbz_pkg::coord_t cx, cbz_pkg::coord_t cy, cbz_pkg::coord_t dx, cbz_pkg::coord_t dy);
    cbz_pkg::req_t r;
    r.p0_x = ax;
    r.p0_y = ay;
    r.p1_x = bx;
    r.p1_y = by;
    r.p2_x = cx;
    r.p2_y = cy;
    r.p3_x = dx;
    r.p3_y = dy;
    return r;
  endfunction

  // coordinate biased toward the edges of the range
  function automatic cbz_pkg::coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_MAX;
      2, 3: return cbz_pkg::coord_t'($urandom_range(0, 15));
      4, 5: return COORD_MAX - cbz_pkg::coord_t'($urandom_range(0, 15));
      default: return cbz_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic cbz_pkg::req_t random_curve();
    return make_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endfunction

  // segment side ready pattern
  initial begin
    int run_left;
    logic level;
    seg_ch.ready <= 1'b0;
    run_left = 0;
    level    = 1'b1;
    forever begin
      @(posedge clk);
      case (stall_style)
        STALL_NONE: begin
          seg_ch.ready <= 1'b1;
        end
        STALL_RANDOM: begin
          seg_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (run_left == 0) begin
            level    = !level;
            run_left = level ? $urandom_range(1, 30) : $urandom_range(1, 20);
          end
          run_left--;
          seg_ch.ready <= level;
        end
      endcase
    end
  end

  // segment checker
  always @(posedge clk) begin : seg_monitor
    segment_t got, want;
    if (!rst && seg_ch.valid && seg_ch.ready) begin
      got.start_x      = seg_ch.start_x;
      got.start_y      = seg_ch.start_y;
      got.end_x        = seg_ch.end_x;
      got.end_y        = seg_ch.end_y;
      got.last_segment = seg_ch.last_segment;
      if (pending_segments.size() == 0) begin
        report_mismatch("segment received with no request outstanding");
      end else begin
        want = pending_segments.pop_front();
        segments_checked++;
        if (got !== want) begin
          report_mismatch($sformatf(
            "segment got (%0d,%0d)->(%0d,%0d) last %b, want (%0d,%0d)->(%0d,%0d) last %b",
            got.start_x, got.start_y, got.end_x, got.end_y, got.last_segment,
            want.start_x, want.start_y, want.end_x, want.end_y, want.last_segment));
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (seg_ch.valid && seg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // corner curves: range extremes, bit patterns, degenerate shapes
  task automatic test_directed_curves();
    sender_gaps = 1'b1;
    stall_style = STALL_RANDOM;
    send_curve(make_curve('0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_curve(make_curve('0, COORD_MAX, '0, COORD_MAX, '0, COORD_MAX, COORD_MAX, '0));
    send_curve(make_curve('0, '0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0));
    send_curve(make_curve(COORD_MAX, '0, '0, COORD_MAX, COORD_MAX, '0, '0, COORD_MAX));
    send_curve(make_curve(11'h555, 11'h2AA, 11'h2AA, 11'h555,
                          11'h555, 11'h2AA, 11'h2AA, 11'h555));
    send_curve(make_curve(11'h2AA, 11'h555, 11'h555, 11'h2AA,
                          11'h2AA, 11'h555, 11'h555, 11'h2AA));
    send_curve(make_curve(11'd0, 11'd0, 11'd682, 11'd682,
                          11'd1365, 11'd1365, 11'd2047, 11'd2047));
    send_curve(make_curve(11'd1000, 11'd37, 11'd1000, 11'd37,
                          11'd1000, 11'd37, 11'd1000, 11'd37));
    send_curve(make_curve(COORD_MAX, COORD_MAX, 11'd1, 11'd2, 11'd1024, 11'd512, '0, '0));
    send_curve(make_curve(11'd1, 11'd2, 11'd4, 11'd8, 11'd16, 11'd32, 11'd64, 11'd128));
    send_curve(make_curve(11'd256, 11'd512, 11'd1024, 11'd1, 11'd2047, 11'd0,
                          11'd1, 11'd1024));
  endtask

  // random curves with bursty requests and random stalls
  task automatic test_random_curves();
    sender_gaps = 1'b1;
    stall_style = STALL_RANDOM;
    repeat (88) send_curve(random_curve());
  endtask

  // back-to-back requests with the segment side always ready
  task automatic test_streaming();
    sender_gaps = 1'b0;
    stall_style = STALL_NONE;
    repeat (40) send_curve(random_curve());
  endtask

  // long stalls on the segment side so the request queue fills up
  task automatic test_long_stalls();
    sender_gaps = 1'b1;
    stall_style = STALL_LONG;
    repeat (40) send_curve(random_curve());
  endtask

  initial begin
    stall_style      = STALL_NONE;
    sender_gaps      = 1'b0;
    burst_left       = 0;
    err_count        = 0;
    curves_sent      = 0;
    segments_checked = 0;
    idle_cycles      = 0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.p0_x  <= '0;
    req_ch.p0_y  <= '0;
    req_ch.p1_x  <= '0;
    req_ch.p1_y  <= '0;
    req_ch.p2_x  <= '0;
    req_ch.p2_y  <= '0;
    req_ch.p3_x  <= '0;
    req_ch.p3_y  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_curves();
    test_random_curves();
    test_streaming();
    test_long_stalls();

    // drain all outstanding segments, then watch for strays
    req_ch.valid <= 1'b0;
    stall_style = STALL_RANDOM;
    while (pending_segments.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d curve requests, %0d segments checked, %0d mismatches",
             curves_sent, segments_checked, err_count);
    $display("covered range extremes, bit patterns, streaming and long stalls");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
